FILE: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the sync sequence correlator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  // request codes of an input item
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_LOAD    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  // unused code, answered with status only
  localparam logic [1:0] REQ_SPARE   = 2'd3;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 20;

  localparam int FIELD_W   = 16;
  localparam int INDEX_W   = 6;
  localparam int LEVEL_W   = 38;
  localparam int CORR_W    = 40;
  localparam int ENERGY_W  = 38;
  localparam int SIDX_W    = 20;
  localparam int WLEN_W    = 7;

  // shared shift-add multiplier
  localparam int PROD_W = 128;
  localparam int MULB_W = 48;

  // threshold 0.7^2 = 49/100
  localparam int THR_L = 100;
  localparam int THR_R = 49;

  // configuration map (64-bit data, 8-byte stride)
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] REG_REVERSE    = 2'd1;
  localparam logic [1:0] REG_LEVEL      = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] sre;
    logic [FIELD_W-1:0] sim;
    logic [INDEX_W-1:0] cidx;
    logic [FIELD_W-1:0] cre;
    logic [FIELD_W-1:0] cim;
  } cmd_t;

  typedef struct packed {
    logic                detected;
    logic                found;
    logic [SIDX_W-1:0]   sample_index;
    logic [CORR_W-1:0]   corr_re;
    logic [CORR_W-1:0]   corr_im;
    logic [ENERGY_W-1:0] energy;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Accepts input items, packs them into commands and queues two of them.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   sample_re,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   sample_im,
  input  wire logic [ssc_pkg::INDEX_W-1:0]   coef_index,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   coef_re,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   coef_im,
  output ssc_pkg::cmd_t                      cmd,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready
);

  ssc_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: req_type, sre: sample_re, sim: sample_im,
                     cidx: coef_index, cre: coef_re, cim: coef_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssc_mul.sv
// ----------------------------------------------------------------------------
// ssc_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when b runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ssc_pkg::PROD_W-1:0]   a_in,
  input  wire logic [ssc_pkg::MULB_W-1:0]   b_in,
  output logic                              done,
  output logic [ssc_pkg::PROD_W-1:0]        prod
);

  logic [ssc_pkg::PROD_W-1:0] a;
  logic [ssc_pkg::MULB_W-1:0] b;
  logic                       busy;

  assign done = busy && (b == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= a_in;
      b    <= b_in;
      prod <= '0;
    end else if (busy && (b != '0)) begin
      if (b[0]) prod <= prod + a;
      a <= {a[ssc_pkg::PROD_W-2:0], 1'b0};
      b <= {1'b0, b[ssc_pkg::MULB_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back
// Runs one command: window and tap memories, correlation scan, threshold test.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_back #(
  parameter int MAX_TAPS    = ssc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ssc_pkg::COUNT_BITS_DEF,
  localparam int NW = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssc_pkg::cmd_t                 cmd,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [NW-1:0]                 win_len,
  input  wire logic                          reverse,
  input  wire logic [ssc_pkg::LEVEL_W-1:0]   level,
  output ssc_pkg::result_t                   res,
  output logic                               res_valid,
  input  wire logic                          res_ready
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int TW    = ssc_pkg::FIELD_W + ssc_pkg::FIELD_W + 1;
  localparam int PW    = SB + ssc_pkg::FIELD_W + 1;
  localparam int ACC_W = SB + 19 + $clog2(MAX_TAPS);
  localparam int EN_W  = 2 * SB + 1 + $clog2(MAX_TAPS);
  localparam int XW    = 10;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_MWAIT  = 3'd4;
  localparam logic [2:0] ST_CMP    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam logic [2:0] M_RE2   = 3'd0;
  localparam logic [2:0] M_IM2   = 3'd1;
  localparam logic [2:0] M_LHS   = 3'd2;
  localparam logic [2:0] M_LVL2  = 3'd3;
  localparam logic [2:0] M_SCALE = 3'd4;
  localparam logic [2:0] M_RHS   = 3'd5;

  logic [2*SB-1:0] win_mem [MAX_TAPS];
  logic [TW-1:0]   tap_mem [MAX_TAPS];
  logic [2*SB-1:0] win_q;
  logic [TW-1:0]   tap_q;

  logic [2:0]            state;
  logic [2:0]            mstep;
  logic [AW-1:0]         wptr;
  logic [NW-1:0]         fill;
  logic [COUNT_BITS-1:0] count;
  logic                  found;
  logic                  do_corr;
  logic                  det;
  logic [NW-1:0]         idx;
  logic [NW-1:0]         thresh;
  logic [AW-1:0]         rd_addr;
  logic                  rd_v;
  logic                  rd_live;
  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;
  logic [EN_W-1:0]         acc_e;
  logic [ssc_pkg::PROD_W-1:0] sq_sum;
  logic [ssc_pkg::PROD_W-1:0] lhs;
  logic [ssc_pkg::PROD_W-1:0] rhs;

  logic win_we;
  logic tap_we;
  logic [AW-1:0] tap_waddr;
  logic [XW-1:0] tap_pos;
  logic load_ok;
  logic accept;
  logic load_res;

  logic [AW+1:0] start_addr;
  logic [AW+1:0] start_wrap;

  logic signed [SB-1:0] sr;
  logic signed [SB-1:0] si;
  logic signed [ssc_pkg::FIELD_W-1:0] tr;
  logic signed [ssc_pkg::FIELD_W:0]   ti;
  logic signed [PW-1:0] p_rr;
  logic signed [PW-1:0] p_ii;
  logic signed [PW-1:0] p_ri;
  logic signed [PW-1:0] p_ir;
  logic signed [2*SB:0] e_term;

  logic [ACC_W-1:0] ar;
  logic [ACC_W-1:0] ai;
  logic                       mul_start;
  logic [ssc_pkg::PROD_W-1:0] mul_a;
  logic [ssc_pkg::MULB_W-1:0] mul_b;
  logic                       mul_done;
  logic [ssc_pkg::PROD_W-1:0] mul_p;

  function automatic logic [ssc_pkg::CORR_W-1:0] sat_corr(input logic signed [ACC_W-1:0] v);
    logic signed [63:0] w;
    logic signed [63:0] hi;
    w  = 64'(v);
    hi = 64'((64'sd1 <<< (ssc_pkg::CORR_W - 1)) - 64'sd1);
    if (w > hi) w = hi;
    else if (w < -hi - 64'sd1) w = -hi - 64'sd1;
    return w[ssc_pkg::CORR_W-1:0];
  endfunction

  function automatic logic [ssc_pkg::ENERGY_W-1:0] sat_energy(input logic [EN_W-1:0] v);
    logic [63:0] w;
    logic [63:0] hi;
    w  = 64'(v);
    hi = (64'd1 << ssc_pkg::ENERGY_W) - 64'd1;
    if (w > hi) w = hi;
    return w[ssc_pkg::ENERGY_W-1:0];
  endfunction

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign load_res  = (state == ST_DONE) && (!res_valid || res_ready);

  // tap placement for a load item
  assign load_ok   = (XW'(cmd.cidx) < XW'(win_len));
  assign tap_pos   = reverse ? (XW'(win_len) - XW'(1) - XW'(cmd.cidx)) : XW'(cmd.cidx);
  assign tap_waddr = tap_pos[AW-1:0];
  assign win_we    = accept && (cmd.kind == ssc_pkg::REQ_SAMPLE) && !found;
  assign tap_we    = accept && (cmd.kind == ssc_pkg::REQ_LOAD) && load_ok;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wptr] <= {cmd.sim[SB-1:0], cmd.sre[SB-1:0]};
    end
    win_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= {-(ssc_pkg::FIELD_W + 1)'($signed(cmd.cim)), cmd.cre};
    end
    tap_q <= tap_mem[idx[AW-1:0]];
  end

  // oldest entry in use sits window_len places behind the write pointer
  always_comb begin
    start_addr = (AW + 2)'(wptr) + (AW + 2)'(MAX_TAPS) - (AW + 2)'(win_len);
    start_wrap = (start_addr >= (AW + 2)'(MAX_TAPS)) ? start_addr - (AW + 2)'(MAX_TAPS)
                                                      : start_addr;
  end

  // entries written before the last restart read as zero
  always_comb begin
    sr     = rd_live ? $signed(win_q[SB-1:0]) : '0;
    si     = rd_live ? $signed(win_q[2*SB-1:SB]) : '0;
    tr     = $signed(tap_q[ssc_pkg::FIELD_W-1:0]);
    ti     = $signed(tap_q[TW-1:ssc_pkg::FIELD_W]);
    p_rr   = PW'(tr) * PW'(sr);
    p_ii   = PW'(ti) * PW'(si);
    p_ri   = PW'(tr) * PW'(si);
    p_ir   = PW'(ti) * PW'(sr);
    e_term = (2 * SB + 1)'(sr) * (2 * SB + 1)'(sr) + (2 * SB + 1)'(si) * (2 * SB + 1)'(si);
  end

  assign ar = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
  assign ai = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mstep)
      M_RE2: begin
        mul_a = ssc_pkg::PROD_W'(ar);
        mul_b = ssc_pkg::MULB_W'(ar);
      end
      M_IM2: begin
        mul_a = ssc_pkg::PROD_W'(ai);
        mul_b = ssc_pkg::MULB_W'(ai);
      end
      M_LHS: begin
        mul_a = sq_sum;
        mul_b = ssc_pkg::MULB_W'(win_len) * ssc_pkg::MULB_W'(ssc_pkg::THR_L);
      end
      M_LVL2: begin
        mul_a = ssc_pkg::PROD_W'(level);
        mul_b = ssc_pkg::MULB_W'(level);
      end
      M_SCALE: begin
        mul_a = rhs;
        mul_b = ssc_pkg::MULB_W'(ssc_pkg::THR_R);
      end
      default: begin
        mul_a = rhs;
        mul_b = ssc_pkg::MULB_W'(acc_e);
      end
    endcase
  end

  assign mul_start = (state == ST_MSTART);

  ssc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mstep   <= M_RE2;
      wptr    <= '0;
      fill    <= '0;
      count   <= '0;
      found   <= 1'b0;
      do_corr <= 1'b0;
      det     <= 1'b0;
      idx     <= '0;
      rd_v    <= 1'b0;
      rd_live <= 1'b0;
      rd_addr <= '0;
      thresh  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            det     <= 1'b0;
            do_corr <= 1'b0;
            state   <= ST_START;
            if (cmd.kind == ssc_pkg::REQ_RESTART) begin
              found <= 1'b0;
              count <= '0;
              fill  <= '0;
            end else if (win_we) begin
              do_corr <= 1'b1;
              wptr    <= (wptr == AW'(MAX_TAPS - 1)) ? '0 : wptr + AW'(1);
              if (fill != NW'(MAX_TAPS)) fill <= fill + NW'(1);
              if (count != '1) count <= count + COUNT_BITS'(1);
            end
          end
        end
        ST_START: begin
          rd_addr <= start_wrap[AW-1:0];
          thresh  <= (win_len > fill) ? win_len - fill : '0;
          idx     <= '0;
          rd_v    <= 1'b0;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx < win_len) begin
            rd_v    <= 1'b1;
            rd_live <= (idx >= thresh);
            idx     <= idx + NW'(1);
            rd_addr <= (rd_addr == AW'(MAX_TAPS - 1)) ? '0 : rd_addr + AW'(1);
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              mstep <= M_RE2;
              state <= (do_corr && (acc_e != '0)) ? ST_MSTART : ST_DONE;
            end
          end
        end
        ST_MSTART: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            mstep <= mstep + 3'd1;
            state <= (mstep == M_RHS) ? ST_CMP : ST_MSTART;
          end
        end
        ST_CMP: begin
          det <= (lhs >= rhs);
          if (lhs >= rhs) found <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_res) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      acc_re <= '0;
      acc_im <= '0;
      acc_e  <= '0;
    end else if (state == ST_SCAN && rd_v) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
      acc_e  <= acc_e + EN_W'($unsigned(e_term));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MWAIT && mul_done) begin
      unique case (mstep)
        M_RE2:   sq_sum <= mul_p;
        M_IM2:   sq_sum <= sq_sum + mul_p;
        M_LHS:   lhs    <= mul_p;
        default: rhs    <= mul_p;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.detected     <= det;
      res.found        <= found;
      res.sample_index <= ssc_pkg::SIDX_W'(count);
      res.corr_re      <= do_corr ? sat_corr(acc_re) : '0;
      res.corr_im      <= do_corr ? sat_corr(acc_im) : '0;
      res.energy       <= sat_energy(acc_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sync_sequence_correlator.sv
// ----------------------------------------------------------------------------
// sync_sequence_correlator
// Normalized complex matched filter that flags a known preamble.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries items: samples, coefficient loads
// and restarts. Output channel out_valid/out_ready returns one result item
// per input item, in order. A two-entry queue sits between the front end and
// the engine, and the result register lets the engine finish its next item
// while a result waits.
// The engine reads one window entry per cycle through the window and tap
// memory ports. A sample that passes the energy check then runs six products
// through the shared shift-add multiplier, one after another, each running
// until no set bit is left in its multiplier operand.
// Reset empties the queue and the result register, clears found and the
// sample count and sets window_len 64, reverse_order 0, detect_level 0. The
// window needs no clearing pass: a fill count marks entries from before the
// last restart as zero. Taps read undefined until loaded.
// A stalled receiver holds the result; the queue fills and in_ready drops.
// Configuration goes through the APB port (8-byte register stride).
// ----------------------------------------------------------------------------
`default_nettype none

module sync_sequence_correlator #(
  parameter int MAX_TAPS    = ssc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ssc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ssc_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssc_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   sample_re,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   sample_im,
  input  wire logic [ssc_pkg::INDEX_W-1:0]   coef_index,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   coef_re,
  input  wire logic [ssc_pkg::FIELD_W-1:0]   coef_im,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               detected,
  output logic                               found,
  output logic [ssc_pkg::SIDX_W-1:0]         sample_index,
  output logic [ssc_pkg::CORR_W-1:0]         corr_re,
  output logic [ssc_pkg::CORR_W-1:0]         corr_im,
  output logic [ssc_pkg::ENERGY_W-1:0]       window_energy
);

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int CW = 10;

  logic [NW-1:0]               win_len;
  logic                        reverse;
  logic [ssc_pkg::LEVEL_W-1:0] level;
  logic [ssc_pkg::WLEN_W-1:0]  wl_raw;
  logic [1:0]                  reg_sel;
  logic                        cfg_we;

  ssc_pkg::cmd_t    cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  ssc_pkg::result_t res;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:3];
  assign wl_raw  = pwdata[ssc_pkg::WLEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= NW'(MAX_TAPS);
      reverse <= 1'b0;
      level   <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        ssc_pkg::REG_WINDOW_LEN: begin
          if (wl_raw == '0) win_len <= NW'(1);
          else if (CW'(wl_raw) > CW'(MAX_TAPS)) win_len <= NW'(MAX_TAPS);
          else win_len <= NW'(wl_raw);
        end
        ssc_pkg::REG_REVERSE: reverse <= pwdata[0];
        ssc_pkg::REG_LEVEL:   level   <= pwdata[ssc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssc_pkg::REG_WINDOW_LEN: prdata = ssc_pkg::PDATA_W'(win_len);
      ssc_pkg::REG_REVERSE:    prdata = ssc_pkg::PDATA_W'(reverse);
      ssc_pkg::REG_LEVEL:      prdata = ssc_pkg::PDATA_W'(level);
      default:                 prdata = '0;
    endcase
  end

  ssc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .coef_index (coef_index),
    .coef_re    (coef_re),
    .coef_im    (coef_im),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready)
  );

  ssc_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .win_len   (win_len),
    .reverse   (reverse),
    .level     (level),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign detected      = res.detected;
  assign found         = res.found;
  assign sample_index  = res.sample_index;
  assign corr_re       = res.corr_re;
  assign corr_im       = res.corr_im;
  assign window_energy = res.energy;

endmodule

`default_nettype wire

FILE: sv/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the correlator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          detected,
  input wire logic                          found,
  input wire logic [ssc_pkg::SIDX_W-1:0]    sample_index,
  input wire logic [ssc_pkg::CORR_W-1:0]    corr_re,
  input wire logic [ssc_pkg::ENERGY_W-1:0]  window_energy
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_index) && $stable(corr_re))
    else $error("stalled result changed");

  a_det_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected |-> found)
    else $error("detection without found flag");

  a_zero_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (window_energy == '0) |-> !detected)
    else $error("detection on empty window");

endmodule

bind sync_sequence_correlator ssc_checker u_ssc_checker (.*);

`default_nettype wire
